// File: rtl/core/fft_overlap_add_convolution_macros.svh
// Assertion macros shared by the convolution block.
`ifndef FFT_OVERLAP_ADD_CONVOLUTION_MACROS_SVH
`define FFT_OVERLAP_ADD_CONVOLUTION_MACROS_SVH
`ifndef SYNTHESIS
`define OAC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define OAC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define OAC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define OAC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/oac_pkg.sv
// Package with shared types and constants of the convolution block.
package oac_pkg;
  localparam int SAMPLE_W = 16;
  localparam int ACC_W    = 34;
  localparam int CFG_IDX_W = 2;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_0 = 2'd0;

  function automatic sample_t round_sat(input acc_t a);
    logic signed [ACC_W:0] r;
    logic signed [ACC_W-14:0] q;
    begin
      r = {a[ACC_W-1], a} + (ACC_W+1)'(8192);
      q = r[ACC_W:14];
      if (q > 32767) round_sat = 16'sh7fff;
      else if (q < -32768) round_sat = 16'sh8000;
      else round_sat = q[SAMPLE_W-1:0];
    end
  endfunction
endpackage

// File: rtl/core/oac_ram.sv
// Generic single-port-write, registered-read RAM.
module oac_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/fft_overlap_add_convolution.sv
// Top level of the overlap-add block convolution.
// Samples are collected into a segment memory; when a segment completes (or an
// end-of-signal item arrives) a sequencer computes each output position with a
// single shared multiplier, reading one segment sample per tap from the
// memory and adding the stored overlap tail. The transform-domain product equals
// this exact linear convolution, so results match bit for bit. For a completing
// item, every tap of every output position costs a memory read step and a
// multiply-accumulate step, and every position adds an emit step and a handoff
// step; a stall of the result side holds a waiting item in the handoff step.
// Input stall is high while a segment is being processed.
`include "fft_overlap_add_convolution_macros.svh"
module fft_overlap_add_convolution
  import oac_pkg::*;
#(
  parameter int SEGMENT_LENGTH = 4,
  parameter int TAP_COUNT = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SAMPLE_W-1:0]  cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [15:0]   in_sample_in,
  input  logic                 in_end_of_signal,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [15:0]   out_sample_out,
  output logic                 out_last_out
);
  localparam int TAIL = (TAP_COUNT > 1) ? TAP_COUNT - 1 : 1;
  localparam int SPAN = SEGMENT_LENGTH + TAP_COUNT - 1;
  localparam int SW = $clog2(SEGMENT_LENGTH + 1);
  localparam int AW = (SEGMENT_LENGTH > 1) ? $clog2(SEGMENT_LENGTH) : 1;
  localparam int PW = $clog2(SPAN + 1);
  localparam int KW = $clog2(TAP_COUNT + 1);
  localparam int TIW = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int TLW = (TAIL > 1) ? $clog2(TAIL) : 1;
  localparam int TAPS_HELD = (TAP_COUNT < 4) ? TAP_COUNT : 4;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_MAC, S_EMIT, S_WAIT} state_t;
  state_t state_r;

  sample_t taps_r [TAP_COUNT];
  acc_t    tail_r [TAIL];
  acc_t    newt_r [TAIL];
  logic [SW-1:0] fill_r, nfill_r;
  logic          last_r;
  logic [PW-1:0] p_r, count_r;
  logic [KW-1:0] k_r;
  acc_t          acc_r;
  logic          tapok_r;
  sample_t       tapv_r;

  logic ram_we;
  logic [AW-1:0] ram_wa, ram_ra;
  logic [SAMPLE_W-1:0] ram_rd;

  assign in_stall = (state_r != S_IDLE);
  wire acc_in = in_valid && !in_stall;
  assign ram_we = acc_in && (fill_r < SW'(SEGMENT_LENGTH));
  assign ram_wa = fill_r[AW-1:0];

  // Sample index p-k, valid when k<=p and p-k<fill.
  logic [PW:0] idx;
  assign idx = {1'b0, p_r} - (PW+1)'(k_r);
  assign ram_ra = idx[AW-1:0];
  wire idx_ok = (k_r < KW'(TAP_COUNT)) && !idx[PW] && (idx < (PW+1)'(nfill_r));

  // Next output position and the offset of the current one into the tail.
  logic [PW-1:0] p_inc, p_off;
  assign p_inc = p_r + 1'b1;
  assign p_off = p_r - PW'(SEGMENT_LENGTH);

  oac_ram #(.WIDTH(SAMPLE_W), .DEPTH(SEGMENT_LENGTH)) u_seg (
    .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(in_sample_in),
    .raddr(ram_ra), .rdata(ram_rd));

  logic signed [2*SAMPLE_W-1:0] prod;
  assign prod = tapv_r * $signed(ram_rd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < TAP_COUNT; i++) taps_r[i] <= '0;
      for (int i = 0; i < TAIL; i++) tail_r[i] <= '0;
    end else begin
      if (cfg_we && 32'(cfg_index) < TAPS_HELD)
        taps_r[cfg_index] <= $signed(cfg_data);
      unique case (state_r)
        S_IDLE: if (acc_in) begin
          if (in_end_of_signal || fill_r + 1'b1 >= SW'(SEGMENT_LENGTH)) begin
            nfill_r <= (fill_r + 1'b1 > SW'(SEGMENT_LENGTH)) ? SW'(SEGMENT_LENGTH)
                                                              : fill_r + 1'b1;
            last_r <= in_end_of_signal;
            count_r <= in_end_of_signal ? PW'(fill_r) + PW'(1) + PW'(TAP_COUNT-1)
                     : (fill_r + 1'b1 > SW'(SEGMENT_LENGTH))
                       ? PW'(SEGMENT_LENGTH) + PW'(TAP_COUNT-1) : PW'(SPAN);
            p_r <= '0;
            k_r <= '0;
            acc_r <= (TAP_COUNT > 1) ? tail_r[0] : '0;
            state_r <= S_READ;
          end else fill_r <= fill_r + 1'b1;
        end
        S_READ: begin
          tapok_r <= idx_ok;
          tapv_r <= taps_r[k_r[TIW-1:0]];
          state_r <= S_MAC;
        end
        S_MAC: begin
          if (tapok_r) acc_r <= acc_r + ACC_W'(prod);
          if (k_r == KW'(TAP_COUNT-1)) state_r <= S_EMIT;
          else begin
            k_r <= k_r + 1'b1;
            state_r <= S_READ;
          end
        end
        S_EMIT: begin
          // The segment positions are always emitted; on end of signal the
          // tail positions within the count are emitted as well.
          if (p_r < PW'(SEGMENT_LENGTH) || (last_r && p_r < count_r)) begin
            out_valid <= 1'b1;
            out_sample_out <= round_sat(acc_r);
            out_last_out <= last_r && (p_inc == count_r);
          end
          // Positions at or beyond the segment length feed the new tail.
          if (p_r >= PW'(SEGMENT_LENGTH) && TAP_COUNT > 1)
            newt_r[p_off[TLW-1:0]] <= acc_r;
          state_r <= S_WAIT;
        end
        S_WAIT: if (!out_valid || !out_stall) begin
          out_valid <= 1'b0;
          if (p_inc >= PW'(SPAN)) begin
            for (int i = 0; i < TAIL; i++)
              tail_r[i] <= (last_r || TAP_COUNT == 1) ? '0 : newt_r[i];
            fill_r <= '0;
            state_r <= S_IDLE;
          end else begin
            p_r <= p_inc;
            k_r <= '0;
            acc_r <= (TAP_COUNT > 1 && p_inc < PW'(TAIL)) ? tail_r[p_inc[TLW-1:0]] : '0;
            state_r <= S_READ;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `OAC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_sample_out) && $stable(out_last_out))
  `OAC_ASSERT_IMP(a_stall_busy, clk, rst_n, state_r != S_IDLE, in_stall)
  `OAC_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_r <= SW'(SEGMENT_LENGTH))
endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the overlap-add block convolution.
module tb_top
  import oac_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEG_LEN = 4;
  localparam int NTAPS = 4;
  localparam int SPAN = SEG_LEN + NTAPS - 1;
  localparam int LIMIT = 2000000;
  // Pause length after the final result.
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    logic signed [15:0] sample;
    logic eos;
  } sig_item_t;

  typedef struct {
    logic signed [15:0] sample;
    logic last;
  } conv_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SAMPLE_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_sample_in = '0;
  logic in_end_of_signal = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_sample_out;
  logic out_last_out;

  fft_overlap_add_convolution u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_sample_in(in_sample_in), .in_end_of_signal(in_end_of_signal),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_sample_out(out_sample_out), .out_last_out(out_last_out)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Predictor state: the filter taps, the partial segment and the carried tail.
  logic signed [15:0] filt_taps [NTAPS];
  logic signed [15:0] seg_samples [SEG_LEN];
  logic signed [33:0] tail_sums [NTAPS-1];
  int held_samples;

  sig_item_t pending_items[$];
  conv_result_t expected_outputs[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  longint cycles = 0;
  bit idle_on = 1'b1;

  function automatic logic signed [15:0] round_to_sample(logic signed [33:0] acc);
    logic signed [34:0] biased;
    logic signed [20:0] q;
    biased = 35'(acc) + 35'sd8192;
    q = 21'(biased >>> 14);
    if (q > 21'sd32767) return 16'sh7fff;
    if (q < -21'sd32768) return 16'sh8000;
    return q[15:0];
  endfunction

  // Folds one accepted sample into the predictor, queueing any results it completes.
  task automatic predict_convolution(sig_item_t it);
    logic signed [33:0] acc [SPAN];
    int fill;
    int count;
    conv_result_t r;
    seg_samples[held_samples] = it.sample;
    held_samples++;
    fill = held_samples;
    if (!it.eos && fill < SEG_LEN) return;
    for (int p = 0; p < SPAN; p++) begin
      acc[p] = (p < NTAPS - 1) ? tail_sums[p] : '0;
      for (int k = 0; k < NTAPS; k++) begin
        if (k <= p && p - k < fill) acc[p] += 34'(filt_taps[k]) * 34'(seg_samples[p - k]);
      end
    end
    count = it.eos ? fill + NTAPS - 1 : SEG_LEN;
    for (int p = 0; p < count; p++) begin
      r.sample = round_to_sample(acc[p]);
      r.last = it.eos && (p + 1 == count);
      expected_outputs.push_back(r);
    end
    for (int p = 0; p < NTAPS - 1; p++) tail_sums[p] = it.eos ? '0 : acc[SEG_LEN + p];
    held_samples = 0;
  endtask

  // Driver: presents pending items, with a random gap drawn per item while idle_on is set.
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_convolution('{in_sample_in, in_end_of_signal});
        n_sent++;
      end
      if (in_valid && in_stall) begin
        // Hold the payload while stalled.
      end else if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_items.size() > 0) begin
        sig_item_t it;
        it = pending_items.pop_front();
        in_valid <= 1'b1;
        in_sample_in <= it.sample;
        in_end_of_signal <= it.eos;
        in_gap <= idle_on ? $urandom_range(0, 14) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each accepted result against the oldest expectation and, while
  // idle_on is set, draws how long the result side stalls after it.
  int out_wait = 0;
  always @(posedge clk) begin
    cycles++;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_outputs.size() == 0) begin
          $error("unexpected result sample_out=%0d last_out=%0b", out_sample_out, out_last_out);
          errors++;
        end else begin
          conv_result_t e;
          e = expected_outputs.pop_front();
          if (out_sample_out !== e.sample) begin
            $error("sample_out: expected %0d, got %0d", e.sample, out_sample_out);
            errors++;
          end
          if (out_last_out !== e.last) begin
            $error("last_out: expected %0b, got %0b", e.last, out_last_out);
            errors++;
          end
          n_checked++;
        end
        out_wait = idle_on ? $urandom_range(0, 14) : 0;
      end else if (out_wait > 0) begin
        out_wait--;
      end
      out_stall <= (out_wait > 0);
    end
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Writes one tap while the block is idle and mirrors it into the predictor.
  task automatic write_tap(int idx, logic signed [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_IDX_W'(REG_TAP_0 + idx);
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    filt_taps[idx] = val;
  endtask

  // Waits until every item was taken and every expected result was seen.
  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || expected_outputs.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // Queues a signal of the given length; only the final sample carries the end mark.
  task automatic queue_signal(int len);
    for (int i = 0; i < len; i++) pending_items.push_back('{rand_sample(), i == len - 1});
  endtask

  initial begin
    for (int i = 0; i < NTAPS; i++) filt_taps[i] = '0;
    for (int i = 0; i < NTAPS - 1; i++) tail_sums[i] = '0;
    held_samples = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: unit taps at positions 0 and 3, then full-scale taps that saturate.
    write_tap(0, 16'sh4000);
    write_tap(1, 16'sh0000);
    write_tap(2, 16'sh0000);
    write_tap(3, 16'sh4000);
    pending_items.push_back('{16'sh7fff, 1'b0});
    pending_items.push_back('{16'sh8000, 1'b0});
    pending_items.push_back('{16'sh0001, 1'b0});
    pending_items.push_back('{-16'sh0001, 1'b0});
    pending_items.push_back('{16'sh1234, 1'b0});
    pending_items.push_back('{16'sh0000, 1'b1});
    pending_items.push_back('{16'sh5555, 1'b1});
    wait_idle();
    write_tap(0, 16'sh7fff);
    write_tap(1, 16'sh8000);
    write_tap(2, 16'sh7fff);
    write_tap(3, 16'sh8000);
    for (int i = 0; i < 8; i++)
      pending_items.push_back('{(i % 2) ? 16'sh8000 : 16'sh7fff, 1'b0});
    pending_items.push_back('{16'sh2aaa, 1'b0});
    pending_items.push_back('{16'shd555, 1'b0});
    pending_items.push_back('{16'sh0003, 1'b1});
    // Sender holds off here until all results are in.
    wait_idle();

    // Random part: several tap settings, signals of random length.
    for (int phase = 0; phase < 5; phase++) begin
      idle_on = (phase != 2);
      for (int i = 0; i < NTAPS; i++) write_tap(i, (phase == 4) ? 16'sh8000 : rand_sample());
      for (int s = 0; s < 4; s++) queue_signal($urandom_range(1, 12));
      wait_idle();
    end

    $display("Covered %0d samples and %0d checked outputs over seven tap settings,", n_sent,
             n_checked);
    $display("including saturation, partial segments and back-to-back end marks.");
    if (errors == 0 && expected_outputs.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// File: fft_overlap_add_convolution.f
+incdir+rtl/core
rtl/core/oac_pkg.sv
rtl/core/oac_ram.sv
rtl/core/fft_overlap_add_convolution.sv
sim/tb_top.sv
